/* hw/rtl/ukl_pkg.sv */
package ukl_pkg;

  // Default geometry
  localparam int unsigned CAPACITY_DEF  = 32;
  localparam int unsigned KEY_BYTES_DEF = 8;

  // Fixed field widths
  localparam int unsigned CMD_W = 2;
  localparam int unsigned KEY_W = 64;
  localparam int unsigned POS_W = 6;
  localparam int unsigned CNT_W = 6;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_GET    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  // Request beat as seen by the sequencer
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] position;
  } req_t;

  // Result beat
  typedef struct packed {
    logic             ok;
    logic [KEY_W-1:0] data;
    logic [CNT_W-1:0] count;
    logic             empty_res;
    logic             full_res;
  } res_t;

endpackage

/* hw/rtl/ukl_in_if.sv */
interface ukl_in_if;
  logic                       valid;
  logic                       ready;
  logic [ukl_pkg::CMD_W-1:0]  cmd;
  logic [ukl_pkg::KEY_W-1:0]  key;
  logic [ukl_pkg::POS_W-1:0]  position;

  modport source (output valid, cmd, key, position, input ready);
  modport sink   (input valid, cmd, key, position, output ready);
endinterface

/* hw/rtl/ukl_out_if.sv */
interface ukl_out_if;
  logic                       valid;
  logic                       ready;
  logic                       ok;
  logic [ukl_pkg::KEY_W-1:0]  data;
  logic [ukl_pkg::CNT_W-1:0]  count;
  logic                       empty_res;
  logic                       full_res;

  modport source (output valid, ok, data, count, empty_res, full_res, input ready);
  modport sink   (input valid, ok, data, count, empty_res, full_res, output ready);
endinterface

/* hw/rtl/ukl_ram.sv */
module ukl_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hw/rtl/ukl_seq.sv */
module ukl_seq #(
  parameter int unsigned CAPACITY  = 32,
  parameter int unsigned KEY_BYTES = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request beat
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  ukl_pkg::req_t                 req_i,
  // result beat
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output ukl_pkg::res_t                 res_o,
  // entry memory
  output logic                          mem_we_o,
  output logic [$clog2(CAPACITY)-1:0]   mem_waddr_o,
  output logic [8*KEY_BYTES-1:0]        mem_wdata_o,
  output logic [$clog2(CAPACITY)-1:0]   mem_raddr_o,
  input  logic [8*KEY_BYTES-1:0]        mem_rdata_i
);
  import ukl_pkg::*;

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned KW   = 8 * KEY_BYTES;
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_GETW,
    S_SRCH,
    S_SHFT,
    S_DONE
  } state_e;

  state_e           state_q, state_d;
  logic [CMD_W-1:0] cmd_q, cmd_d;
  logic [KW-1:0]    key_q, key_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    count_q, count_d;
  logic             ok_q, ok_d;
  logic [KEY_W-1:0] data_q, data_d;

  logic [CW-1:0]    idx_nx;
  logic [CW-1:0]    idx_m1;
  logic [POS_W-1:0] pos_m1;
  logic             pos_ok;
  logic             last;

  assign idx_nx = idx_q + CW'(1);
  assign idx_m1 = idx_q - CW'(1);
  assign pos_m1 = pos_q - POS_W'(1);
  assign last   = !(idx_nx < count_q);
  assign pos_ok = (pos_q != '0) && (CMPW'(pos_q) <= CMPW'(count_q));

  // Next-state and memory access logic
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    count_d     = count_q;
    ok_d        = ok_q;
    data_d      = data_q;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = key_q;
    mem_raddr_o = '0;

    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_d   = req_i.cmd;
          key_d   = req_i.key[KW-1:0];
          pos_d   = req_i.position;
          ok_d    = 1'b0;
          data_d  = '0;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_DONE;
        case (cmd_q)
          CMD_INSERT: begin
            if (count_q < CAP_C) begin
              mem_we_o    = 1'b1;
              mem_waddr_o = count_q[AW-1:0];
              count_d     = count_q + CW'(1);
              ok_d        = 1'b1;
            end
          end
          CMD_GET: begin
            if (pos_ok) begin
              mem_raddr_o = AW'(pos_m1);
              state_d     = S_GETW;
            end
          end
          CMD_REMOVE: begin
            if (count_q != '0) begin
              mem_raddr_o = '0;
              idx_d       = '0;
              state_d     = S_SRCH;
            end
          end
          default: ;
        endcase
      end
      S_GETW: begin
        data_d  = KEY_W'(mem_rdata_i);
        ok_d    = 1'b1;
        state_d = S_DONE;
      end
      // Linear scan for the first matching entry
      S_SRCH: begin
        if (mem_rdata_i == key_q) begin
          if (last) begin
            count_d = count_q - CW'(1);
            ok_d    = 1'b1;
            state_d = S_DONE;
          end else begin
            mem_raddr_o = idx_nx[AW-1:0];
            idx_d       = idx_nx;
            state_d     = S_SHFT;
          end
        end else if (last) begin
          state_d = S_DONE;
        end else begin
          mem_raddr_o = idx_nx[AW-1:0];
          idx_d       = idx_nx;
        end
      end
      // Close the gap: entry idx moves to idx-1 while idx+1 is fetched
      S_SHFT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_m1[AW-1:0];
        mem_wdata_o = mem_rdata_i;
        if (last) begin
          count_d = count_q - CW'(1);
          ok_d    = 1'b1;
          state_d = S_DONE;
        end else begin
          mem_raddr_o = idx_nx[AW-1:0];
          idx_d       = idx_nx;
        end
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ok_q    <= ok_d;
    end
  end

  // Item payload, no reset needed
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    key_q  <= key_d;
    pos_q  <= pos_d;
    idx_q  <= idx_d;
    data_q <= data_d;
  end

  assign res_o.ok        = ok_q;
  assign res_o.data      = data_q;
  assign res_o.count     = CNT_W'(count_q);
  assign res_o.empty_res = (count_q == '0);
  assign res_o.full_res  = (count_q == CAP_C);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_C)
    else $error("entry count above capacity");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (state_q == S_EXEC || state_q == S_SHFT))
    else $error("memory write outside insert or shift");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH || state_q == S_SHFT) |-> idx_q < count_q)
    else $error("scan index beyond count");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && cmd_q == CMD_INSERT && count_q < CAP_C)
    |=> count_q == $past(count_q) + CW'(1))
    else $error("insert did not bump count");

endmodule

/* hw/rtl/unordered_key_list_table.sv */
// Insert writes in S_EXEC; get reads in S_EXEC and captures in S_GETW; remove scans entries
//   in S_SRCH and shifts later ones down in S_SHFT; each result goes via S_DONE to the output register.
// Throughput: one item at a time; the next input beat is taken once the previous result
//   has moved to the output register, set by the entry-by-entry scan/shift over entry RAM.
// Reset: asynchronous active low; clears count and handshake state, entry RAM is not
//   cleared (entries at or above the count are never read).
module unordered_key_list_table #(
  parameter int unsigned CAPACITY  = ukl_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_BYTES = ukl_pkg::KEY_BYTES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  ukl_in_if.sink           in_i,
  ukl_out_if.source        out_o
);
  import ukl_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned KW = 8 * KEY_BYTES;

  req_t          req;
  res_t          res;
  logic          res_valid;
  logic          res_ready;
  logic          res_take;
  logic          out_valid_q;
  res_t          out_res_q;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [KW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [KW-1:0] mem_rdata;

  assign req.cmd      = in_i.cmd;
  assign req.key      = in_i.key;
  assign req.position = in_i.position;

  ukl_seq #(
    .CAPACITY  (CAPACITY),
    .KEY_BYTES (KEY_BYTES)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_i.valid),
    .req_ready_o (in_i.ready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  ukl_ram #(
    .WIDTH (KW),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Output register: refills in the cycle it drains
  assign res_ready = !out_valid_q || out_o.ready;
  assign res_take  = res_valid && res_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.ok        = out_res_q.ok;
  assign out_o.data      = out_res_q.data;
  assign out_o.count     = out_res_q.count;
  assign out_o.empty_res = out_res_q.empty_res;
  assign out_o.full_res  = out_res_q.full_res;

endmodule
